>>> rtl/point_rotator_2d_core_macros.svh
// Assertion macros shared by the point rotator RTL.
`ifndef POINT_ROTATOR_2D_CORE_MACROS_SVH
`define POINT_ROTATOR_2D_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define PROT_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("point rotator: property failed");
`define PROT_ASSERT_IMPLY(lbl, clk_s, rst_s, pre, post) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (pre) |-> (post)) \
    else $error("point rotator: implication failed");
`else
`define PROT_ASSERT(lbl, clk_s, rst_s, prop)
`define PROT_ASSERT_IMPLY(lbl, clk_s, rst_s, pre, post)
`endif
`endif

>>> rtl/prot_pkg.sv
// Shared types and constants for the point rotator.
`timescale 1ns / 1ps
`default_nettype none
package prot_pkg;

  localparam int ANGLE_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int ATAN_DEPTH = 32;

  // reciprocal of the limiting CORDIC gain, unsigned Q0.32
  localparam logic [31:0] GAIN_Q32 = 32'h9B74EDA8;

  typedef logic [ANGLE_BITS-1:0] angle_t;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } quadrant_t;

  // atan(2^-i) in units of full circle / 2^32
  localparam angle_t ATAN_TABLE [ATAN_DEPTH] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
  };

endpackage
`default_nettype wire

>>> rtl/prot_gain.sv
// Gain scaling, angle reduction and quarter-turn pre-rotation (two stages).
`timescale 1ns / 1ps
`default_nettype none
module prot_gain
  import prot_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int ANGLE_WIDTH = 16,
  parameter int WORK_WIDTH  = 33
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          valid_in,
  input  wire logic signed [COORD_WIDTH-1:0] x_in,
  input  wire logic signed [COORD_WIDTH-1:0] y_in,
  input  wire logic signed [COORD_WIDTH-1:0] z_in,
  input  wire logic signed [ANGLE_WIDTH-1:0] turn_angle,
  output logic                               valid_out,
  output logic signed [WORK_WIDTH-1:0]       x_out,
  output logic signed [WORK_WIDTH-1:0]       y_out,
  output logic signed [COORD_WIDTH-1:0]      z_out,
  output angle_t                             resid_out
);

  localparam int PROD_WIDTH = COORD_WIDTH + 33;
  localparam logic signed [32:0] GAIN_S = {1'b0, GAIN_Q32};
  localparam angle_t HALF_QUAD = angle_t'(1) << (ANGLE_BITS - 3);

  logic signed [PROD_WIDTH-1:0] x_prod;
  logic signed [PROD_WIDTH-1:0] y_prod;
  angle_t                       angle_full;
  angle_t                       angle_biased;
  quadrant_t                    quad_next;
  angle_t                       resid_next;

  // stage 1 registers
  logic                         valid_s1;
  logic signed [WORK_WIDTH-1:0] x_s1;
  logic signed [WORK_WIDTH-1:0] y_s1;
  logic signed [COORD_WIDTH-1:0] z_s1;
  quadrant_t                    quad_s1;
  angle_t                       resid_s1;

  logic signed [WORK_WIDTH-1:0] x_rot;
  logic signed [WORK_WIDTH-1:0] y_rot;

  assign x_prod = x_in * GAIN_S;
  assign y_prod = y_in * GAIN_S;

  // binary angle in the top bits of a 32-bit full circle
  assign angle_full   = angle_t'(turn_angle) << (ANGLE_BITS - ANGLE_WIDTH);
  assign angle_biased = angle_full + HALF_QUAD;
  assign quad_next    = quadrant_t'(angle_biased[ANGLE_BITS-1 -: 2]);
  assign resid_next   = angle_full - {angle_biased[ANGLE_BITS-1 -: 2], {(ANGLE_BITS-2){1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s1 <= 1'b0;
    end else begin
      valid_s1 <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    x_s1     <= x_prod[WORK_WIDTH+FRAC_BITS-1:FRAC_BITS];
    y_s1     <= y_prod[WORK_WIDTH+FRAC_BITS-1:FRAC_BITS];
    z_s1     <= z_in;
    quad_s1  <= quad_next;
    resid_s1 <= resid_next;
  end

  always_comb begin
    unique case (quad_s1)
      QUAD_0: begin
        x_rot = x_s1;
        y_rot = y_s1;
      end
      QUAD_1: begin
        x_rot = -y_s1;
        y_rot = x_s1;
      end
      QUAD_2: begin
        x_rot = -x_s1;
        y_rot = -y_s1;
      end
      QUAD_3: begin
        x_rot = y_s1;
        y_rot = -x_s1;
      end
      default: begin
        x_rot = x_s1;
        y_rot = y_s1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_s1;
    end
  end

  always_ff @(posedge clk) begin
    x_out     <= x_rot;
    y_out     <= y_rot;
    z_out     <= z_s1;
    resid_out <= resid_s1;
  end

endmodule
`default_nettype wire

>>> rtl/prot_stage.sv
// One registered CORDIC micro-rotation.
`timescale 1ns / 1ps
`default_nettype none
module prot_stage
  import prot_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int WORK_WIDTH  = 33,
  parameter int STEP_INDEX  = 0
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          valid_in,
  input  wire logic signed [WORK_WIDTH-1:0]  x_in,
  input  wire logic signed [WORK_WIDTH-1:0]  y_in,
  input  wire logic signed [COORD_WIDTH-1:0] z_in,
  input  wire angle_t                        resid_in,
  output logic                               valid_out,
  output logic signed [WORK_WIDTH-1:0]       x_out,
  output logic signed [WORK_WIDTH-1:0]       y_out,
  output logic signed [COORD_WIDTH-1:0]      z_out,
  output angle_t                             resid_out
);

  localparam angle_t STEP_ANGLE = ATAN_TABLE[STEP_INDEX];

  logic signed [WORK_WIDTH-1:0] dx;
  logic signed [WORK_WIDTH-1:0] dy;
  logic                         go_ccw;

  // arithmetic shift is a floor divide by 2^i
  assign dx     = y_in >>> STEP_INDEX;
  assign dy     = x_in >>> STEP_INDEX;
  assign go_ccw = !resid_in[ANGLE_BITS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    z_out <= z_in;
    if (go_ccw) begin
      x_out     <= x_in - dx;
      y_out     <= y_in + dy;
      resid_out <= resid_in - STEP_ANGLE;
    end else begin
      x_out     <= x_in + dx;
      y_out     <= y_in - dy;
      resid_out <= resid_in + STEP_ANGLE;
    end
  end

endmodule
`default_nettype wire

>>> rtl/prot_out.sv
// Round half up, saturate to the coordinate range, register the result.
`timescale 1ns / 1ps
`default_nettype none
module prot_out
  import prot_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int WORK_WIDTH  = 33
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          valid_in,
  input  wire logic signed [WORK_WIDTH-1:0]  x_in,
  input  wire logic signed [WORK_WIDTH-1:0]  y_in,
  input  wire logic signed [COORD_WIDTH-1:0] z_in,
  output logic                               valid_out,
  output logic signed [COORD_WIDTH-1:0]      x_out,
  output logic signed [COORD_WIDTH-1:0]      y_out,
  output logic signed [COORD_WIDTH-1:0]      z_out
);

  localparam int RND_WIDTH = WORK_WIDTH + 1 - FRAC_BITS;
  localparam logic signed [WORK_WIDTH:0] HALF_LSB =
    (WORK_WIDTH+1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [RND_WIDTH-1:0] SAT_MAX =
    RND_WIDTH'({1'b0, {(COORD_WIDTH-1){1'b1}}});
  localparam logic signed [RND_WIDTH-1:0] SAT_MIN =
    {{(RND_WIDTH-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

  logic signed [WORK_WIDTH:0]    x_sum;
  logic signed [WORK_WIDTH:0]    y_sum;
  logic signed [RND_WIDTH-1:0]   x_rnd;
  logic signed [RND_WIDTH-1:0]   y_rnd;
  logic signed [COORD_WIDTH-1:0] x_sat;
  logic signed [COORD_WIDTH-1:0] y_sat;

  assign x_sum = {x_in[WORK_WIDTH-1], x_in} + HALF_LSB;
  assign y_sum = {y_in[WORK_WIDTH-1], y_in} + HALF_LSB;
  assign x_rnd = x_sum[WORK_WIDTH:FRAC_BITS];
  assign y_rnd = y_sum[WORK_WIDTH:FRAC_BITS];

  always_comb begin
    if (x_rnd > SAT_MAX) begin
      x_sat = SAT_MAX[COORD_WIDTH-1:0];
    end else if (x_rnd < SAT_MIN) begin
      x_sat = SAT_MIN[COORD_WIDTH-1:0];
    end else begin
      x_sat = x_rnd[COORD_WIDTH-1:0];
    end
    if (y_rnd > SAT_MAX) begin
      y_sat = SAT_MAX[COORD_WIDTH-1:0];
    end else if (y_rnd < SAT_MIN) begin
      y_sat = SAT_MIN[COORD_WIDTH-1:0];
    end else begin
      y_sat = y_rnd[COORD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    x_out <= x_sat;
    y_out <= y_sat;
    z_out <= z_in;
  end

endmodule
`default_nettype wire

>>> rtl/point_rotator_2d_core.sv
// An accepted start passes through two gain/pre-rotation stages, one stage per
// CORDIC step and one rounding stage before the done strobe.
// Throughput: one point per cycle; the pipeline never stalls, so busy stays low.
// Reset (synchronous, active high) clears the valid bits; no request in flight
// survives it, and data registers are left as they are.
`timescale 1ns / 1ps
`default_nettype none
`include "point_rotator_2d_core_macros.svh"
module point_rotator_2d_core
  import prot_pkg::*;
#(
  parameter int COORD_WIDTH    = 16,
  parameter int ANGLE_WIDTH    = 16,
  parameter int ROTATION_STEPS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [COORD_WIDTH-1:0] x_in,
  input  wire logic signed [COORD_WIDTH-1:0] y_in,
  input  wire logic signed [COORD_WIDTH-1:0] z_in,
  input  wire logic signed [ANGLE_WIDTH-1:0] turn_angle,
  output logic                               done,
  output logic signed [COORD_WIDTH-1:0]      x_out,
  output logic signed [COORD_WIDTH-1:0]      y_out,
  output logic signed [COORD_WIDTH-1:0]      z_out
);

  localparam int WORK_WIDTH = COORD_WIDTH + 17;
  localparam int LATENCY    = ROTATION_STEPS + 3;

  logic                          pipe_valid [ROTATION_STEPS+1];
  logic signed [WORK_WIDTH-1:0]  pipe_x     [ROTATION_STEPS+1];
  logic signed [WORK_WIDTH-1:0]  pipe_y     [ROTATION_STEPS+1];
  logic signed [COORD_WIDTH-1:0] pipe_z     [ROTATION_STEPS+1];
  angle_t                        pipe_resid [ROTATION_STEPS];

  assign busy = 1'b0;

  prot_gain #(
    .COORD_WIDTH (COORD_WIDTH),
    .ANGLE_WIDTH (ANGLE_WIDTH),
    .WORK_WIDTH  (WORK_WIDTH)
  ) u_gain (
    .clk        (clk),
    .rst        (rst),
    .valid_in   (start && !busy),
    .x_in       (x_in),
    .y_in       (y_in),
    .z_in       (z_in),
    .turn_angle (turn_angle),
    .valid_out  (pipe_valid[0]),
    .x_out      (pipe_x[0]),
    .y_out      (pipe_y[0]),
    .z_out      (pipe_z[0]),
    .resid_out  (pipe_resid[0])
  );

  for (genvar i = 0; i < ROTATION_STEPS; i++) begin : g_step
    if (i < ROTATION_STEPS - 1) begin : g_mid
      prot_stage #(
        .COORD_WIDTH (COORD_WIDTH),
        .WORK_WIDTH  (WORK_WIDTH),
        .STEP_INDEX  (i)
      ) u_stage (
        .clk       (clk),
        .rst       (rst),
        .valid_in  (pipe_valid[i]),
        .x_in      (pipe_x[i]),
        .y_in      (pipe_y[i]),
        .z_in      (pipe_z[i]),
        .resid_in  (pipe_resid[i]),
        .valid_out (pipe_valid[i+1]),
        .x_out     (pipe_x[i+1]),
        .y_out     (pipe_y[i+1]),
        .z_out     (pipe_z[i+1]),
        .resid_out (pipe_resid[i+1])
      );
    end else begin : g_last
      // residual after the final step is not needed
      prot_stage #(
        .COORD_WIDTH (COORD_WIDTH),
        .WORK_WIDTH  (WORK_WIDTH),
        .STEP_INDEX  (i)
      ) u_stage (
        .clk       (clk),
        .rst       (rst),
        .valid_in  (pipe_valid[i]),
        .x_in      (pipe_x[i]),
        .y_in      (pipe_y[i]),
        .z_in      (pipe_z[i]),
        .resid_in  (pipe_resid[i]),
        .valid_out (pipe_valid[i+1]),
        .x_out     (pipe_x[i+1]),
        .y_out     (pipe_y[i+1]),
        .z_out     (pipe_z[i+1]),
        .resid_out ()
      );
    end
  end

  prot_out #(
    .COORD_WIDTH (COORD_WIDTH),
    .WORK_WIDTH  (WORK_WIDTH)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (pipe_valid[ROTATION_STEPS]),
    .x_in      (pipe_x[ROTATION_STEPS]),
    .y_in      (pipe_y[ROTATION_STEPS]),
    .z_in      (pipe_z[ROTATION_STEPS]),
    .valid_out (done),
    .x_out     (x_out),
    .y_out     (y_out),
    .z_out     (z_out)
  );

  `PROT_ASSERT(a_done_has_request, clk, rst, done |-> $past(start, LATENCY))
  `PROT_ASSERT_IMPLY(a_z_passthrough, clk, rst, done, z_out == $past(z_in, LATENCY))
  `PROT_ASSERT_IMPLY(a_origin, clk, rst, done && $past(~|{x_in, y_in}, LATENCY), (~|{x_out, y_out}))

endmodule
`default_nettype wire
